[src/rwc_pkg.sv]
// Shared types, constants and helpers for the recent word cache.
package rwc_pkg;

  localparam logic [1:0] MODE_UPSERT = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_NOP    = 2'd3;

  localparam int unsigned MAX_OUT = 32;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [1:0]  HINT_ANY  = 2'h3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } rwc_state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] key_bytes;
    logic [7:0]  key_length;
    logic [7:0]  hint_bits;
    logic [7:0]  tone_value;
    logic [63:0] word_low;
    logic [63:0] word_high;
    logic [4:0]  word_length;
    logic [31:0] now_time;
    logic [5:0]  result_limit;
  } rwc_req_t;

  typedef struct packed {
    logic        valid_res;
    logic [63:0] out_word_low;
    logic [63:0] out_word_high;
    logic [4:0]  out_word_length;
    logic [7:0]  out_tone;
    logic        last;
  } rwc_res_t;

  typedef struct packed {
    logic [63:0] key;
    logic [3:0]  key_length;
    logic [7:0]  hints;
    logic [7:0]  tone;
    logic [63:0] word_low;
    logic [63:0] word_high;
    logic [4:0]  word_length;
    logic [31:0] time_ms;
    logic [15:0] uses;
  } rwc_entry_t;

  // compare unit verdicts for one table entry
  typedef struct packed {
    logic exact_hit;
    logic lk_match;
    logic newer;
    logic older;
    logic same_word;
  } rwc_cmp_t;

  // low n bytes set, all ones from eight up
  function automatic logic [63:0] byte_mask(input logic [4:0] n);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (n > 5'(b)) m[8*b +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

[src/rwc_ram.sv]
// Generic single-port-write, registered-read RAM.
module rwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

[src/rwc_cmp.sv]
// Shared entry compare unit: match, rank and word checks for one entry.
module rwc_cmp (
  input  rwc_pkg::rwc_req_t   req,
  input  rwc_pkg::rwc_entry_t ent,
  input  rwc_pkg::rwc_entry_t best,
  input  rwc_pkg::rwc_res_t   prev,
  output rwc_pkg::rwc_cmp_t   res
);
  import rwc_pkg::*;

  logic [63:0] kmask;
  logic        hints_ok;
  logic [1:0]  s, u;

  always_comb begin
    kmask    = byte_mask({1'b0, ent.key_length});
    hints_ok = 1'b1;
    for (int k = 0; k < 4; k++) begin
      s = ent.hints[2*k +: 2];
      u = req.hint_bits[2*k +: 2];
      if (ent.key_length > 4'(k) && s != HINT_ANY && u != HINT_ANY && s != u)
        hints_ok = 1'b0;
    end

    res.exact_hit = ({4'd0, ent.key_length} == req.key_length) &&
                    (ent.hints == req.hint_bits) &&
                    (ent.word_length == req.word_length) &&
                    (ent.key == req.key_bytes) &&
                    (ent.word_low == req.word_low) &&
                    (ent.word_high == req.word_high);

    res.lk_match = (ent.key_length != 4'd0) &&
                   ({4'd0, ent.key_length} <= req.key_length) &&
                   !(ent.key_length == 4'd1 && req.key_length != 8'd1) &&
                   (((req.key_bytes ^ ent.key) & kmask) == 64'd0) &&
                   hints_ok;

    res.newer = (ent.time_ms > best.time_ms) ||
                (ent.time_ms == best.time_ms && ent.uses > best.uses);
    res.older = (ent.time_ms < best.time_ms) ||
                (ent.time_ms == best.time_ms && ent.uses < best.uses);

    res.same_word = (ent.word_low == prev.out_word_low) &&
                    (ent.word_high == prev.out_word_high) &&
                    (ent.word_length == prev.out_word_length);
  end
endmodule

[src/recent_word_cache_unit.sv]
// Top level of the recent word cache: sequencer, table RAM and compare unit.
//
// channel   ports                      handshake
// request   start, busy, in_req        taken when start=1 and busy=0
// result    out_strobe, out_res        one-cycle strobe, cannot be stalled
//
// Valid upserts, and lookups with a nonzero key length and limit, walk the
// table one entry per cycle through the single compare unit; the RAM read
// port paces the walk. Upsert takes one pass, lookup one pass per emitted
// candidate plus a final pass that finds nothing unless the limit is reached
// first. Clear and ignored requests make no pass. Reset empties the table at
// once (no clearing sweep). Each candidate is held for one pass so the final
// one can carry last; busy drops in the cycle that carries the last result.
module recent_word_cache_unit #(
  parameter int CAPACITY   = 32,
  parameter int WORD_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rwc_pkg::rwc_req_t in_req,
  output logic              out_strobe,
  output rwc_pkg::rwc_res_t out_res
);
  import rwc_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = $bits(rwc_entry_t);

  rwc_state_t state_r, state_nxt;
  rwc_req_t   req_r, req_nxt;
  logic [CW-1:0] idx_r, idx_nxt, count_r, count_nxt;
  logic          rv_r;
  logic [AW-1:0] rv_idx_r;
  logic [CAPACITY-1:0] done_r, done_nxt;
  logic          best_found_r, best_found_nxt;
  logic [AW-1:0] best_idx_r, best_idx_nxt;
  rwc_entry_t    best_r, best_nxt;
  logic          hit_found_r, hit_found_nxt;
  logic [AW-1:0] hit_idx_r, hit_idx_nxt;
  logic [15:0]   hit_cnt_r, hit_cnt_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  rwc_res_t      pend_r, pend_nxt;
  logic [5:0]    nout_r, nout_nxt, limit_r, limit_nxt;
  logic          strobe_r, strobe_nxt;
  rwc_res_t      res_r, res_nxt;

  // table port
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  rwc_entry_t    wr_ent, rd_ent;
  logic [EW-1:0] rd_raw;

  rwc_cmp_t cmp;

  // pass status after taking the entry in flight into account
  logic          f_found;
  logic [AW-1:0] f_idx;
  rwc_entry_t    f_ent;
  logic          end_pass, accept, up_ok;
  logic [5:0]    lim_in;

  rwc_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_ent),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_raw)
  );
  assign rd_ent = rwc_entry_t'(rd_raw);

  rwc_cmp u_cmp (
    .req  (req_r),
    .ent  (rd_ent),
    .best (best_r),
    .prev (pend_r),
    .res  (cmp)
  );

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign end_pass   = (state_r == ST_SCAN) && (idx_r == count_r);
  assign out_strobe = strobe_r;
  assign out_res    = res_r;

  assign up_ok  = (in_req.key_length >= 8'd1) && (in_req.key_length <= 8'd8) &&
                  (in_req.word_length >= 5'd1) &&
                  ({27'd0, in_req.word_length} <= 32'(WORD_BYTES));
  assign lim_in = (in_req.result_limit > 6'(MAX_OUT)) ? 6'(MAX_OUT)
                                                       : in_req.result_limit;

  // best candidate including this cycle's entry
  always_comb begin
    f_found = best_found_r;
    f_idx   = best_idx_r;
    f_ent   = best_r;
    if (rv_r) begin
      if (req_r.mode == MODE_LOOKUP) begin
        if (cmp.lk_match && !done_r[rv_idx_r] &&
            !(pend_valid_r && cmp.same_word) &&
            (!best_found_r || cmp.newer)) begin
          f_found = 1'b1;
          f_idx   = rv_idx_r;
          f_ent   = rd_ent;
        end
      end else if (!best_found_r || cmp.older) begin
        // eviction victim: oldest, then lowest count, then lowest index
        f_found = 1'b1;
        f_idx   = rv_idx_r;
        f_ent   = rd_ent;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_req.mode == MODE_UPSERT && up_ok) state_nxt = ST_SCAN;
          else if (in_req.mode == MODE_LOOKUP) begin
            if (in_req.key_length == 8'd0 || lim_in == 6'd0) state_nxt = ST_FINISH;
            else state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (end_pass) begin
          if (req_r.mode != MODE_LOOKUP) state_nxt = ST_IDLE;
          else if (!f_found || (nout_r + 6'd1 == limit_r)) state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    req_nxt        = req_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    done_nxt       = done_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_nxt       = best_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_cnt_nxt    = hit_cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    nout_nxt       = nout_r;
    limit_nxt      = limit_r;
    strobe_nxt     = 1'b0;
    res_nxt        = res_r;
    wr_en          = 1'b0;
    wr_addr        = hit_idx_r;
    wr_ent         = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt           = in_req;
          // stored bytes past the lengths are zero
          req_nxt.key_bytes = in_req.key_bytes & byte_mask(in_req.key_length > 8'd8 ?
                                                           5'd8 : in_req.key_length[4:0]);
          req_nxt.word_low  = in_req.word_low & byte_mask(in_req.word_length);
          req_nxt.word_high = (in_req.word_length > 5'd8) ?
                              (in_req.word_high & byte_mask(in_req.word_length - 5'd8)) :
                              64'd0;
          idx_nxt        = '0;
          done_nxt       = '0;
          best_found_nxt = 1'b0;
          hit_found_nxt  = 1'b0;
          pend_valid_nxt = 1'b0;
          pend_nxt       = '0;
          nout_nxt       = '0;
          limit_nxt      = lim_in;
          if (in_req.mode == MODE_CLEAR) count_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (!end_pass) idx_nxt = idx_r + CW'(1);
        if (rv_r) begin
          if (req_r.mode == MODE_LOOKUP) begin
            if (pend_valid_r && cmp.same_word) done_nxt[rv_idx_r] = 1'b1;
          end else if (cmp.exact_hit && !hit_found_r) begin
            hit_found_nxt = 1'b1;
            hit_idx_nxt   = rv_idx_r;
            hit_cnt_nxt   = rd_ent.uses;
          end
        end
        best_found_nxt = f_found;
        best_idx_nxt   = f_idx;
        best_nxt       = f_ent;

        if (end_pass) begin
          if (req_r.mode == MODE_LOOKUP) begin
            if (f_found) begin
              if (pend_valid_r) begin
                strobe_nxt = 1'b1;
                res_nxt    = pend_r;
              end
              pend_valid_nxt           = 1'b1;
              pend_nxt.valid_res       = 1'b1;
              pend_nxt.out_word_low    = f_ent.word_low;
              pend_nxt.out_word_high   = f_ent.word_high;
              pend_nxt.out_word_length = f_ent.word_length;
              pend_nxt.out_tone        = f_ent.tone;
              pend_nxt.last            = 1'b0;
              done_nxt[f_idx]          = 1'b1;
              nout_nxt                 = nout_r + 6'd1;
              idx_nxt                  = '0;
              best_found_nxt           = 1'b0;
            end
          end else begin
            wr_en              = 1'b1;
            wr_ent.key         = req_r.key_bytes;
            wr_ent.key_length  = req_r.key_length[3:0];
            wr_ent.hints       = req_r.hint_bits;
            wr_ent.tone        = req_r.tone_value;
            wr_ent.word_low    = req_r.word_low;
            wr_ent.word_high   = req_r.word_high;
            wr_ent.word_length = req_r.word_length;
            wr_ent.time_ms     = req_r.now_time;
            if (hit_found_nxt) begin
              wr_addr     = hit_idx_nxt;
              wr_ent.uses = (hit_cnt_nxt == COUNT_MAX) ? COUNT_MAX
                                                       : hit_cnt_nxt + 16'd1;
            end else begin
              wr_ent.uses = 16'd1;
              if (count_r < CW'(CAPACITY)) begin
                wr_addr   = count_r[AW-1:0];
                count_nxt = count_r + CW'(1);
              end else begin
                wr_addr = f_idx;
              end
            end
          end
        end
      end
      ST_FINISH: begin
        strobe_nxt = 1'b1;
        res_nxt    = pend_valid_r ? pend_r : '0;
        res_nxt.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      rv_r         <= 1'b0;
      strobe_r     <= 1'b0;
      pend_valid_r <= 1'b0;
      best_found_r <= 1'b0;
      hit_found_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      rv_r         <= (state_r == ST_SCAN) && (idx_r < count_r);
      strobe_r     <= strobe_nxt;
      pend_valid_r <= pend_valid_nxt;
      best_found_r <= best_found_nxt;
      hit_found_r  <= hit_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    rv_idx_r   <= idx_r[AW-1:0];
    done_r     <= done_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_cnt_r  <= hit_cnt_nxt;
    pend_r     <= pend_nxt;
    nout_r     <= nout_nxt;
    limit_r    <= limit_nxt;
    res_r      <= res_nxt;
  end
endmodule

[test/recent_word_cache_unit_checker.sv]
// Checker for the recent word cache: predicts every lookup result and compares.
`timescale 1ns / 100ps
module recent_word_cache_unit_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  rwc_pkg::rwc_req_t in_req,
  input  logic              out_strobe,
  input  rwc_pkg::rwc_res_t out_res,
  output int                fail_count,
  output int                pending_count
);
  import rwc_pkg::*;

  localparam int CAP = 32;

  rwc_entry_t table_q [CAP];
  int unsigned live_entries;
  rwc_res_t candidate_q [$];

  assign pending_count = candidate_q.size();

  function automatic logic [63:0] low_bytes(input int unsigned n);
    if (n >= 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic bit hints_ok(input logic [7:0] s, input logic [7:0] u,
                                  input int unsigned klen);
    for (int k = 0; k < 4 && k < klen; k++) begin
      if (s[2*k +: 2] != HINT_ANY && u[2*k +: 2] != HINT_ANY &&
          s[2*k +: 2] != u[2*k +: 2]) return 0;
    end
    return 1;
  endfunction

  // newer time first, then higher count, then lower index
  function automatic bit outranks(input int a, input int b);
    if (table_q[a].time_ms != table_q[b].time_ms)
      return table_q[a].time_ms > table_q[b].time_ms;
    if (table_q[a].uses != table_q[b].uses)
      return table_q[a].uses > table_q[b].uses;
    return a < b;
  endfunction

  task automatic apply_upsert(input rwc_req_t r);
    int unsigned klen, wlen, slot;
    logic [63:0] key, wlo, whi;
    klen = 32'(r.key_length);
    wlen = 32'(r.word_length);
    if (klen < 1 || klen > 8 || wlen < 1 || wlen > 16) return;
    key = r.key_bytes & low_bytes(klen);
    wlo = r.word_low & low_bytes(wlen);
    whi = (wlen > 8) ? (r.word_high & low_bytes(wlen - 8)) : 64'd0;
    for (int i = 0; i < live_entries; i++) begin
      if (table_q[i].key_length == klen && table_q[i].hints == r.hint_bits &&
          table_q[i].word_length == wlen && table_q[i].key == key &&
          table_q[i].word_low == wlo && table_q[i].word_high == whi) begin
        table_q[i].time_ms = r.now_time;
        if (table_q[i].uses != COUNT_MAX) table_q[i].uses++;
        table_q[i].tone = r.tone_value;
        return;
      end
    end
    if (live_entries < CAP) begin
      slot = live_entries;
      live_entries++;
    end else begin
      slot = 0;
      for (int i = 1; i < CAP; i++)
        if (table_q[i].time_ms < table_q[slot].time_ms ||
            (table_q[i].time_ms == table_q[slot].time_ms &&
             table_q[i].uses < table_q[slot].uses)) slot = i;
    end
    table_q[slot] = '{key: key, key_length: 4'(klen), hints: r.hint_bits,
                      tone: r.tone_value, word_low: wlo, word_high: whi,
                      word_length: 5'(wlen), time_ms: r.now_time, uses: 16'd1};
  endtask

  task automatic predict_lookup(input rwc_req_t r);
    int unsigned ulen, lim, kl;
    int hits [$];
    int cur, j;
    rwc_res_t got [$];
    rwc_res_t res;
    bit dup;
    ulen = 32'(r.key_length);
    lim = (r.result_limit > 6'd32) ? 32 : 32'(r.result_limit);
    if (ulen != 0 && lim != 0) begin
      for (int i = 0; i < live_entries; i++) begin
        kl = 32'(table_q[i].key_length);
        if (kl == 0 || kl > ulen) continue;
        if (kl == 1 && ulen != 1) continue;
        if (((r.key_bytes ^ table_q[i].key) & low_bytes(kl)) != 0) continue;
        if (!hints_ok(table_q[i].hints, r.hint_bits, kl)) continue;
        hits.push_back(i);
      end
      for (int i = 1; i < hits.size(); i++) begin
        cur = hits[i];
        j = i;
        while (j > 0 && outranks(cur, hits[j-1])) begin
          hits[j] = hits[j-1];
          j--;
        end
        hits[j] = cur;
      end
      foreach (hits[i]) begin
        if (got.size() >= lim) break;
        dup = 0;
        foreach (got[g])
          if (got[g].out_word_low == table_q[hits[i]].word_low &&
              got[g].out_word_high == table_q[hits[i]].word_high &&
              got[g].out_word_length == table_q[hits[i]].word_length) dup = 1;
        if (dup) continue;
        res = '{valid_res: 1'b1, out_word_low: table_q[hits[i]].word_low,
                out_word_high: table_q[hits[i]].word_high,
                out_word_length: table_q[hits[i]].word_length,
                out_tone: table_q[hits[i]].tone, last: 1'b0};
        got.push_back(res);
      end
    end
    if (got.size() == 0) begin
      res = '0;
      got.push_back(res);
    end
    got[got.size()-1].last = 1'b1;
    foreach (got[g]) candidate_q.push_back(got[g]);
  endtask

  always @(posedge clk) begin
    rwc_res_t exp_res;
    if (!rst_n) begin
      live_entries = 0;
      candidate_q.delete();
      fail_count = 0;
    end else begin
      if (out_strobe) begin
        if (candidate_q.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, out_res);
          fail_count++;
        end else begin
          exp_res = candidate_q.pop_front();
          if (out_res !== exp_res) begin
            $display("%0t: result mismatch, expected %p, actual %p",
                     $time, exp_res, out_res);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        case (in_req.mode)
          MODE_UPSERT: apply_upsert(in_req);
          MODE_LOOKUP: predict_lookup(in_req);
          MODE_CLEAR: live_entries = 0;
          default: ;
        endcase
      end
    end
  end
endmodule

[test/recent_word_cache_unit_tb.sv]
// Testbench top for the recent word cache: request stimulus and verdict.
`timescale 1ns / 100ps
module recent_word_cache_unit_tb;
  import rwc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk, rst_n, start, busy, out_strobe;
  rwc_req_t in_req;
  rwc_res_t out_res;
  int fail_count, pending_count;
  int cycles;
  int idle_pct;
  logic [31:0] clock_ms;
  // small pool of keys and words so lookups find hits and upserts refresh
  logic [63:0] key_pool [4];
  logic [63:0] word_pool [6];

  recent_word_cache_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_strobe(out_strobe), .out_res(out_res)
  );

  recent_word_cache_unit_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_strobe(out_strobe), .out_res(out_res),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // hold a request until it is taken, then drop start
  task automatic send_request(input rwc_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    in_req <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    // taken at this edge
    @(negedge clk);
    start <= 1'b0;
  endtask

  function automatic rwc_req_t rand_req(input logic [1:0] mode);
    rwc_req_t r;
    r.mode = mode;
    r.key_bytes = {$urandom, $urandom};
    r.key_length = 8'($urandom_range(8, 1));
    r.hint_bits = 8'($urandom);
    r.tone_value = 8'($urandom);
    r.word_low = {$urandom, $urandom};
    r.word_high = {$urandom, $urandom};
    r.word_length = 5'($urandom_range(16, 1));
    r.now_time = $urandom;
    r.result_limit = 6'($urandom_range(32, 1));
    return r;
  endfunction

  // mostly well-formed requests drawn from the pools, some raw noise
  function automatic rwc_req_t pool_req();
    rwc_req_t r;
    int pick;
    pick = $urandom_range(99);
    r = rand_req((pick < 55) ? MODE_UPSERT : (pick < 95) ? MODE_LOOKUP :
                 (pick < 97) ? MODE_CLEAR : MODE_NOP);
    if ($urandom_range(9) < 8) begin
      r.key_bytes = key_pool[2'($urandom_range(3))];
      r.word_low = word_pool[3'($urandom_range(5))];
      r.word_high = word_pool[3'($urandom_range(5))];
      r.hint_bits = ($urandom_range(1)) ? 8'hFF : 8'($urandom_range(3) * 8'h55);
      r.word_length = 5'($urandom_range(3) == 0 ? 16 : $urandom_range(4, 1));
      r.key_length = 8'($urandom_range(4, 1));
    end
    if (r.mode == MODE_LOOKUP && $urandom_range(3) == 0) r.key_length = 8'd8;
    if ($urandom_range(19) == 0) r.key_length = 8'($urandom);
    if ($urandom_range(19) == 0) r.word_length = 5'($urandom);
    if ($urandom_range(19) == 0) r.result_limit = 6'($urandom);
    if ($urandom_range(2) == 0) begin
      r.now_time = clock_ms;
      clock_ms = clock_ms + $urandom_range(2);
    end
    return r;
  endfunction

  initial begin
    rwc_req_t r;
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    idle_pct = 0;
    clock_ms = 32'd1000;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    foreach (word_pool[i]) word_pool[i] = {$urandom, $urandom};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty lookup, bad lengths, extremes, prefix at length one
    r = rand_req(MODE_LOOKUP); send_request(r);
    r = rand_req(MODE_UPSERT); r.key_length = 8'd0; send_request(r);
    r = rand_req(MODE_UPSERT); r.key_length = 8'd9; send_request(r);
    r = rand_req(MODE_UPSERT); r.word_length = 5'd0; send_request(r);
    r = rand_req(MODE_UPSERT); r.word_length = 5'd17; send_request(r);
    r = '1; r.mode = MODE_UPSERT; r.key_length = 8'd8; r.word_length = 5'd16;
    send_request(r);
    r = '1; r.mode = MODE_UPSERT; r.key_length = 8'd8; r.word_length = 5'd16;
    r.tone_value = 8'h00; send_request(r);  // refresh hit
    r = '1; r.mode = MODE_LOOKUP; r.key_length = 8'hFF; r.result_limit = 6'h3F;
    send_request(r);
    r = '0; r.mode = MODE_UPSERT; r.key_length = 8'd1; r.word_length = 5'd1;
    r.key_bytes = 64'h41; r.word_low = 64'h61; send_request(r);
    r.word_low = 64'h62; r.key_length = 8'd2; r.key_bytes = 64'h4241; send_request(r);
    r = '0; r.mode = MODE_LOOKUP; r.key_bytes = 64'h4241; r.key_length = 8'd1;
    r.result_limit = 6'd32; send_request(r);
    r.key_length = 8'd2; send_request(r);
    r.key_length = 8'd3; r.hint_bits = 8'hFF; send_request(r);
    r.result_limit = 6'd0; send_request(r);
    r.result_limit = 6'd1; send_request(r);
    r.key_length = 8'd0; r.result_limit = 6'd5; send_request(r);
    r = rand_req(MODE_NOP); send_request(r);
    r = rand_req(MODE_CLEAR); send_request(r);
    r = '0; r.mode = MODE_LOOKUP; r.key_bytes = 64'h41; r.key_length = 8'd1;
    r.result_limit = 6'd32; send_request(r);

    // random phases drawn from the pools, with varying idle gaps
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 50 : (ph == 2) ? 0 : 38;
      for (int n = 0; n < 12; n++) begin
        r = pool_req();
        send_request(r);
      end
    end
    // fill past capacity then a wide lookup
    for (int n = 0; n < 35; n++) begin
      r = pool_req();
      r.mode = MODE_UPSERT;
      send_request(r);
    end
    r = pool_req(); r.mode = MODE_LOOKUP; r.key_length = 8'd8; r.hint_bits = 8'hFF;
    r.result_limit = 6'd32; send_request(r);

    while (pending_count != 0 || busy) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
